// ===== design/mbox_pkg.sv =====
// ============================================================================
// mbox_pkg
// Shared widths, register indexes, the orbit record and saturating helpers
// for the Mandelbox membership pipeline.
// ============================================================================
package mbox_pkg;

    localparam int MAX_ITERATIONS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 24;

    localparam int POINT_W    = 32;
    localparam int IW         = 64;
    localparam int DR_W       = 63;
    localparam int THR_W      = 32;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Quotient bits of the radius divider, retired two per stage
    localparam int QUO_W      = 66;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam int LANES      = 4;
    localparam int DR_LANE    = 3;

    localparam int THR7_W = THR_W + 3;
    localparam int PROD_W = THR7_W + DR_W;
    localparam int SQ_W   = 2 * IW;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd167772;
    localparam logic [CNT_W-1:0] COUNT_RESET     = 5'd10;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_DISTANCE_THRESHOLD = 4'd0;
    localparam cfg_idx_t REG_ITERATION_COUNT    = 4'd1;

    localparam logic [IW-1:0]   INT_MIN = {1'b1, {(IW-1){1'b0}}};
    localparam logic [IW-1:0]   INT_MAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic [DR_W-1:0] DR_MAX  = {DR_W{1'b1}};

    typedef struct packed {
        logic [2:0][IW-1:0] v;
        logic [2:0][IW-1:0] pos;
        logic [DR_W-1:0]    dr;
        logic               sat;
    } orbit_t;

    // {overflow, a + b clamped to the signed range}
    function automatic logic [IW:0] sat_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {a[IW-1], a} + {b[IW-1], b};
        if (s[IW] != s[IW-1])
        begin
            return {1'b1, s[IW], {(IW-1){~s[IW]}}};
        end
        return {1'b0, s[IW-1:0]};
    endfunction

    function automatic logic [IW-1:0] mag(input logic [IW-1:0] a);
        return a[IW-1] ? (IW'(0) - a) : a;
    endfunction

    // {overflow, 2 * dr clamped}; dr is always positive
    function automatic logic [DR_W:0] dr_double(input logic [DR_W-1:0] dr);
        if (dr[DR_W-1])
        begin
            return {1'b1, DR_MAX};
        end
        return {1'b0, dr[DR_W-2:0], 1'b0};
    endfunction

endpackage

// ===== design/mbox_if.sv =====
// ============================================================================
// mbox channel interfaces
// Point input, result output and register write channels, valid/ready.
// ============================================================================
interface mbox_point_if;
    import mbox_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic signed [POINT_W-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface mbox_result_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic saturated;

    modport source (output valid, output inside_res, output saturated, input ready);
    modport sink   (input valid, input inside_res, input saturated, output ready);
endinterface

interface mbox_cfg_if;
    import mbox_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/mandelbox_membership_test_core.sv =====
// ============================================================================
// mandelbox_membership_test_core
// Mandelbox membership test for Q8.24 points, fully pipelined.
// ============================================================================
// Usage:
//   point  : one transaction carries point_x/y/z (signed Q8.24).
//   result : one transaction per point, in order: inside_res and saturated.
//   cfg    : index 0 writes distance_threshold, index 1 iteration_count;
//            always ready. Write only while no point is in flight.
// Throughput: one point per cycle while the result side keeps up.
// Pipeline: each iteration costs 38 stages, 33 of them the two-bit-per-stage
//   radius divider.
// Every iteration stage is built; iterations beyond iteration_count pass the
//   orbit through unchanged, so latency does not depend on the count.
// Stall: results wait in a two-entry queue; while it is full the whole
//   pipeline holds and point.ready is low. Nothing is lost or repeated.
// Reset: empties the pipeline and queue, threshold returns to 0.01 and
//   iteration_count to 10.
// ============================================================================
module mandelbox_membership_test_core #(
    parameter int MAX_ITERATIONS = mbox_pkg::MAX_ITERATIONS_DEF,
    parameter int FRACTION_BITS  = mbox_pkg::FRACTION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    mbox_point_if.sink     point,
    mbox_result_if.source  result,
    mbox_cfg_if.sink       cfg
);
    import mbox_pkg::*;

    localparam int F = FRACTION_BITS;

    // ---------------- configuration ----------------
    logic [THR_W-1:0] thr_reg;
    logic [THR_W-1:0] thr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        thr_next   = thr_reg;
        count_next = count_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_DISTANCE_THRESHOLD: thr_next   = cfg.data[THR_W-1:0];
                REG_ITERATION_COUNT:    count_next = cfg.data[CNT_W-1:0];
                default:                thr_next   = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THRESHOLD_RESET;
            count_reg <= COUNT_RESET;
        end
        else
        begin
            thr_reg   <= thr_next;
            count_reg <= count_next;
        end
    end

    // ---------------- entry stage ----------------
    logic          en;
    logic          entry_valid_reg;
    orbit_t        entry_orbit_reg;
    orbit_t        entry_orbit_next;
    logic [IW-1:0] coord;

    assign point.ready = en;

    always_comb
    begin
        entry_orbit_next.sat = 1'b0;
        entry_orbit_next.dr  = DR_W'(1) << F;
        coord                = '0;
        for (int i = 0; i < 3; i++)
        begin
            case (i)
                0:       coord = IW'(point.point_x);
                1:       coord = IW'(point.point_y);
                default: coord = IW'(point.point_z);
            endcase
            // scale by seven
            entry_orbit_next.v[i]   = (coord << 3) - coord;
            entry_orbit_next.pos[i] = (coord << 3) - coord;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            entry_valid_reg <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_orbit_reg <= entry_orbit_next;
        end
    end

    // ---------------- iteration chain ----------------
    logic   chain_valid [MAX_ITERATIONS+1];
    orbit_t chain_orbit [MAX_ITERATIONS+1];

    assign chain_valid[0] = entry_valid_reg;
    assign chain_orbit[0] = entry_orbit_reg;

    for (genvar n = 0; n < MAX_ITERATIONS; n++)
    begin : g_iter
        mbox_iter #(
            .FRACTION_BITS(FRACTION_BITS),
            .ITER         (n)
        ) u_iter (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .count    (count_reg),
            .in_valid (chain_valid[n]),
            .in_orbit (chain_orbit[n]),
            .out_valid(chain_valid[n+1]),
            .out_orbit(chain_orbit[n+1])
        );
    end

    // ---------------- distance test and result queue ----------------
    logic fin_valid;
    logic fin_inside;
    logic fin_sat;

    mbox_final #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .threshold (thr_reg),
        .in_valid  (chain_valid[MAX_ITERATIONS]),
        .in_orbit  (chain_orbit[MAX_ITERATIONS]),
        .out_valid (fin_valid),
        .out_inside(fin_inside),
        .out_sat   (fin_sat)
    );

    mbox_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fin_valid && en),
        .push_inside(fin_inside),
        .push_sat   (fin_sat),
        .space      (en),
        .result     (result)
    );

endmodule

// ===== design/mbox_div_step.sv =====
// ============================================================================
// mbox_div_step
// One registered stage of the radius divider: retires two restoring quotient
// bits on each of the four lanes and carries the orbit alongside.
// ============================================================================
module mbox_div_step #(
    parameter int FRACTION_BITS = mbox_pkg::FRACTION_BITS_DEF
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  en,
    input  logic                                                  in_valid,
    input  mbox_pkg::orbit_t                                      in_orbit,
    input  logic                                                  in_med,
    input  logic [FRACTION_BITS-1:0]                              in_div,
    input  logic [mbox_pkg::LANES-1:0][FRACTION_BITS-1:0]         in_rem,
    input  logic [mbox_pkg::LANES-1:0][mbox_pkg::QUO_W-1:0]       in_low,
    output logic                                                  out_valid,
    output mbox_pkg::orbit_t                                      out_orbit,
    output logic                                                  out_med,
    output logic [FRACTION_BITS-1:0]                              out_div,
    output logic [mbox_pkg::LANES-1:0][FRACTION_BITS-1:0]         out_rem,
    output logic [mbox_pkg::LANES-1:0][mbox_pkg::QUO_W-1:0]       out_low
);
    import mbox_pkg::*;

    localparam int F = FRACTION_BITS;

    logic                             valid_reg;
    orbit_t                           orbit_reg;
    logic                             med_reg;
    logic [F-1:0]                     div_reg;
    logic [LANES-1:0][F-1:0]          rem_reg;
    logic [LANES-1:0][F-1:0]          rem_next;
    logic [LANES-1:0][QUO_W-1:0]      low_reg;
    logic [LANES-1:0][QUO_W-1:0]      low_next;
    logic [F:0]                       trial;
    logic [F:0]                       div_ext;
    logic [F-1:0]                     rem_w;
    logic [QUO_W-1:0]                 low_w;
    logic                             qbit;

    always_comb
    begin
        div_ext  = {1'b0, in_div};
        rem_next = in_rem;
        low_next = in_low;
        trial    = '0;
        rem_w    = '0;
        low_w    = '0;
        qbit     = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            rem_w = in_rem[l];
            low_w = in_low[l];
            for (int b = 0; b < DIV_BITS; b++)
            begin
                trial = {rem_w, low_w[QUO_W-1]};
                qbit  = (trial >= div_ext);
                rem_w = qbit ? F'(trial - div_ext) : trial[F-1:0];
                low_w = {low_w[QUO_W-2:0], qbit};
            end
            rem_next[l] = rem_w;
            low_next[l] = low_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            orbit_reg <= in_orbit;
            med_reg   <= in_med;
            div_reg   <= in_div;
            rem_reg   <= rem_next;
            low_reg   <= low_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_orbit = orbit_reg;
    assign out_med   = med_reg;
    assign out_div   = div_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;

endmodule

// ===== design/mbox_iter.sv =====
// ============================================================================
// mbox_iter
// One fold iteration: box fold, squared radius, sphere fold through a
// pipelined divider, then scale by two and add the orbit constant.
// ============================================================================
module mbox_iter #(
    parameter int FRACTION_BITS = mbox_pkg::FRACTION_BITS_DEF,
    parameter int ITER          = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [mbox_pkg::CNT_W-1:0] count,
    input  logic                       in_valid,
    input  mbox_pkg::orbit_t           in_orbit,
    output logic                       out_valid,
    output mbox_pkg::orbit_t           out_orbit
);
    import mbox_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int R2_W = F + 2;
    localparam int NW   = DR_W + F;

    localparam logic [IW-1:0]   ONE     = {{(IW-1){1'b0}}, 1'b1} << F;
    localparam logic [IW-1:0]   TWO     = ONE << 1;
    localparam logic [IW-1:0]   NEG_ONE = -ONE;
    localparam logic [IW-1:0]   NEG_TWO = -TWO;
    localparam logic [R2_W-1:0] R2_ONE  = R2_W'(1) << F;
    localparam logic [R2_W-1:0] R2_QTR  = R2_W'(1) << (F - 2);

    logic act;
    assign act = (32'(count) > ITER);

    // ---------------- fold stage ----------------
    logic             a_valid_reg;
    orbit_t           a_orbit_reg;
    orbit_t           a_orbit_next;
    logic             a_small_reg;
    logic             a_small_next;
    logic [IW-1:0]    fold_v;

    always_comb
    begin
        a_orbit_next = in_orbit;
        a_small_next = act;
        fold_v       = '0;
        for (int i = 0; i < 3; i++)
        begin
            fold_v = in_orbit.v[i];
            if ($signed(fold_v) > $signed(ONE))
            begin
                fold_v = TWO - fold_v;
            end
            else if ($signed(fold_v) < $signed(NEG_ONE))
            begin
                // the most negative value stays pinned and flags
                if (fold_v == INT_MIN)
                begin
                    if (act)
                    begin
                        a_orbit_next.sat = 1'b1;
                    end
                end
                else
                begin
                    fold_v = NEG_TWO - fold_v;
                end
            end
            if (!($signed(fold_v) < $signed(ONE) && $signed(fold_v) > $signed(NEG_ONE)))
            begin
                a_small_next = 1'b0;
            end
            if (act)
            begin
                a_orbit_next.v[i] = fold_v;
            end
        end
    end

    // ---------------- square stage ----------------
    logic                 b_valid_reg;
    orbit_t               b_orbit_reg;
    logic                 b_small_reg;
    logic [2:0][2*F-1:0]  b_sq_reg;
    logic [2:0][2*F-1:0]  b_sq_next;
    logic [2:0][IW-1:0]   b_mag;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_mag[i]     = mag(a_orbit_reg.v[i]);
            b_sq_next[i] = b_mag[i][F-1:0] * b_mag[i][F-1:0];
        end
    end

    // ---------------- radius stage ----------------
    logic                             c_valid_reg;
    orbit_t                           c_orbit_reg;
    orbit_t                           c_orbit_next;
    logic                             c_med_reg;
    logic                             c_med_next;
    logic [F-1:0]                     c_div_reg;
    logic [LANES-1:0][F-1:0]          c_rem_reg;
    logic [LANES-1:0][F-1:0]          c_rem_next;
    logic [LANES-1:0][QUO_W-1:0]      c_low_reg;
    logic [LANES-1:0][QUO_W-1:0]      c_low_next;
    logic [R2_W-1:0]                  r2;
    logic                             tiny;
    logic [DR_W:0]                    dr_x2;
    logic [DR_W:0]                    dr_x4;
    logic [2:0][IW-1:0]               c_mag;
    logic [LANES-1:0][NW-1:0]         num;

    always_comb
    begin
        r2 = R2_W'(b_sq_reg[0][2*F-1:F]) + R2_W'(b_sq_reg[1][2*F-1:F])
           + R2_W'(b_sq_reg[2][2*F-1:F]);
        tiny         = b_small_reg && (r2 < R2_QTR);
        c_med_next   = b_small_reg && (r2 >= R2_QTR) && (r2 < R2_ONE);
        c_orbit_next = b_orbit_reg;
        dr_x2        = dr_double(b_orbit_reg.dr);
        dr_x4        = dr_double(dr_x2[DR_W-1:0]);
        if (tiny)
        begin
            // magnitudes are below one, so four times cannot overflow
            for (int i = 0; i < 3; i++)
            begin
                c_orbit_next.v[i] = {b_orbit_reg.v[i][IW-3:0], 2'b00};
            end
            c_orbit_next.dr  = dr_x4[DR_W-1:0];
            c_orbit_next.sat = b_orbit_reg.sat | dr_x2[DR_W] | dr_x4[DR_W];
        end
        for (int i = 0; i < 3; i++)
        begin
            c_mag[i] = mag(b_orbit_reg.v[i]);
            num[i]   = {DR_W'(c_mag[i][F-1:0]), {F{1'b0}}};
        end
        num[DR_LANE] = {b_orbit_reg.dr, {F{1'b0}}};
        for (int l = 0; l < LANES; l++)
        begin
            c_rem_next[l] = F'(num[l][NW-1:QUO_W]);
            c_low_next[l] = num[l][QUO_W-1:0];
        end
    end

    // ---------------- divider chain ----------------
    logic                             dv_valid [DIV_STAGES+1];
    orbit_t                           dv_orbit [DIV_STAGES+1];
    logic                             dv_med   [DIV_STAGES+1];
    logic [F-1:0]                     dv_div   [DIV_STAGES+1];
    logic [LANES-1:0][F-1:0]          dv_rem   [DIV_STAGES+1];
    logic [LANES-1:0][QUO_W-1:0]      dv_low   [DIV_STAGES+1];

    assign dv_valid[0] = c_valid_reg;
    assign dv_orbit[0] = c_orbit_reg;
    assign dv_med[0]   = c_med_reg;
    assign dv_div[0]   = c_div_reg;
    assign dv_rem[0]   = c_rem_reg;
    assign dv_low[0]   = c_low_reg;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        mbox_div_step #(
            .FRACTION_BITS(FRACTION_BITS)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (dv_valid[s]),
            .in_orbit (dv_orbit[s]),
            .in_med   (dv_med[s]),
            .in_div   (dv_div[s]),
            .in_rem   (dv_rem[s]),
            .in_low   (dv_low[s]),
            .out_valid(dv_valid[s+1]),
            .out_orbit(dv_orbit[s+1]),
            .out_med  (dv_med[s+1]),
            .out_div  (dv_div[s+1]),
            .out_rem  (dv_rem[s+1]),
            .out_low  (dv_low[s+1])
        );
    end

    // ---------------- inversion and doubling stage ----------------
    logic          d_valid_reg;
    orbit_t        d_orbit_reg;
    orbit_t        d_orbit_next;
    orbit_t        inv_orbit;
    logic [IW-1:0] quo;
    logic [IW:0]   dbl;
    logic [DR_W:0] dr_dbl;

    always_comb
    begin
        inv_orbit = dv_orbit[DIV_STAGES];
        quo       = '0;
        if (dv_med[DIV_STAGES])
        begin
            for (int i = 0; i < 3; i++)
            begin
                quo = dv_low[DIV_STAGES][i][IW-1:0];
                inv_orbit.v[i] = dv_orbit[DIV_STAGES].v[i][IW-1] ? (IW'(0) - quo) : quo;
            end
            if (|dv_low[DIV_STAGES][DR_LANE][QUO_W-1:DR_W])
            begin
                inv_orbit.dr  = DR_MAX;
                inv_orbit.sat = 1'b1;
            end
            else
            begin
                inv_orbit.dr = dv_low[DIV_STAGES][DR_LANE][DR_W-1:0];
            end
        end
        d_orbit_next = inv_orbit;
        dbl          = '0;
        dr_dbl       = dr_double(inv_orbit.dr);
        if (act)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dbl = sat_add(inv_orbit.v[i], inv_orbit.v[i]);
                d_orbit_next.v[i] = dbl[IW-1:0];
                d_orbit_next.sat  = d_orbit_next.sat | dbl[IW];
            end
            d_orbit_next.dr  = dr_dbl[DR_W-1:0];
            d_orbit_next.sat = d_orbit_next.sat | dr_dbl[DR_W];
        end
    end

    // ---------------- constant add stage ----------------
    logic        e_valid_reg;
    orbit_t      e_orbit_reg;
    orbit_t      e_orbit_next;
    logic [IW:0] addc;

    always_comb
    begin
        e_orbit_next = d_orbit_reg;
        addc         = '0;
        if (act)
        begin
            for (int i = 0; i < 3; i++)
            begin
                addc = sat_add(d_orbit_reg.v[i], d_orbit_reg.pos[i]);
                e_orbit_next.v[i] = addc[IW-1:0];
                e_orbit_next.sat  = e_orbit_next.sat | addc[IW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= dv_valid[DIV_STAGES];
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_orbit_reg <= a_orbit_next;
            a_small_reg <= a_small_next;
            b_orbit_reg <= a_orbit_reg;
            b_small_reg <= a_small_reg;
            b_sq_reg    <= b_sq_next;
            c_orbit_reg <= c_orbit_next;
            c_med_reg   <= c_med_next;
            c_div_reg   <= r2[F-1:0];
            c_rem_reg   <= c_rem_next;
            c_low_reg   <= c_low_next;
            d_orbit_reg <= d_orbit_next;
            e_orbit_reg <= e_orbit_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_orbit = e_orbit_reg;

endmodule

// ===== design/mbox_final.sv =====
// ============================================================================
// mbox_final
// Distance test: |v|^2 against (7 * threshold * dr)^2, with products split
// into 32-bit partials across registered stages.
// ============================================================================
module mbox_final #(
    parameter int FRACTION_BITS = mbox_pkg::FRACTION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [mbox_pkg::THR_W-1:0] threshold,
    input  logic                       in_valid,
    input  mbox_pkg::orbit_t           in_orbit,
    output logic                       out_valid,
    output logic                       out_inside,
    output logic                       out_sat
);
    import mbox_pkg::*;

    localparam int F = FRACTION_BITS;

    logic [6:0] valid_reg;
    logic [6:0] sat_reg;

    // magnitudes and scaled threshold
    logic [2:0][IW-1:0]  m_reg;
    logic [THR7_W-1:0]   thr7_reg;
    logic [DR_W-1:0]     dr_reg;

    // partial products
    logic [2:0][63:0]    p00_reg;
    logic [2:0][63:0]    p01_reg;
    logic [2:0][63:0]    p11_reg;
    logic [THR7_W+31:0]  pb0_reg;
    logic [THR7_W+30:0]  pb1_reg;

    // recombined
    logic [2:0][SQ_W-1:0] sq_reg;
    logic [PROD_W-1:0]    prod_reg;

    logic [SQ_W-1:0]      rr3_reg;
    logic [DR_W-1:0]      bound_reg;
    logic                 bsat;

    logic [SQ_W-1:0]      rr4_reg;
    logic [63:0]          q00_reg;
    logic [62:0]          q01_reg;
    logic [61:0]          q11_reg;

    logic [SQ_W-1:0]      rr5_reg;
    logic [SQ_W-1:0]      mm_reg;

    logic                 inside_reg;

    assign bsat = |prod_reg[PROD_W-1:DR_W+F];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= {sat_reg[5:3], sat_reg[2] | bsat, sat_reg[1:0], in_orbit.sat};

            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= mag(in_orbit.v[i]);
            end
            thr7_reg <= (THR7_W'(threshold) << 3) - THR7_W'(threshold);
            dr_reg   <= in_orbit.dr;

            for (int i = 0; i < 3; i++)
            begin
                p00_reg[i] <= m_reg[i][31:0]  * m_reg[i][31:0];
                p01_reg[i] <= m_reg[i][31:0]  * m_reg[i][63:32];
                p11_reg[i] <= m_reg[i][63:32] * m_reg[i][63:32];
            end
            pb0_reg <= thr7_reg * dr_reg[31:0];
            pb1_reg <= thr7_reg * dr_reg[DR_W-1:32];

            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= {p11_reg[i], 64'd0} + (SQ_W'(p01_reg[i]) << 33)
                           + SQ_W'(p00_reg[i]);
            end
            prod_reg <= (PROD_W'(pb1_reg) << 32) + PROD_W'(pb0_reg);

            rr3_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            bound_reg <= bsat ? DR_MAX : prod_reg[DR_W+F-1:F];

            rr4_reg <= rr3_reg;
            q00_reg <= bound_reg[31:0] * bound_reg[31:0];
            q01_reg <= bound_reg[31:0] * bound_reg[DR_W-1:32];
            q11_reg <= bound_reg[DR_W-1:32] * bound_reg[DR_W-1:32];

            rr5_reg <= rr4_reg;
            mm_reg  <= (SQ_W'(q11_reg) << 64) + (SQ_W'(q01_reg) << 33) + SQ_W'(q00_reg);

            inside_reg <= (rr5_reg < mm_reg);
        end
    end

    assign out_valid  = valid_reg[6];
    assign out_inside = inside_reg;
    assign out_sat    = sat_reg[6];

endmodule

// ===== design/mbox_outq.sv =====
// ============================================================================
// mbox_outq
// Two-entry result queue; its fill level gates the whole pipeline.
// ============================================================================
module mbox_outq (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  logic   push_inside,
    input  logic   push_sat,
    output logic   space,
    mbox_result_if.source result
);
    localparam logic [1:0] FULL = 2'd2;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] slot_reg [2];
    logic       pop;

    assign pop   = result.valid && result.ready;
    assign space = (count_reg != FULL);

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= {push_inside, push_sat};
        end
    end

    assign result.valid      = (count_reg != 2'd0);
    assign result.inside_res = slot_reg[rd_ptr_reg][1];
    assign result.saturated  = slot_reg[rd_ptr_reg][0];

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != FULL))
        else $error("result pushed into a full queue");

    a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue level did not rise on push");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue level did not fall on pop");

endmodule

// ===== verif/mandelbox_membership_test_core_checker.sv =====
// ----------------------------------------------------------------------------
// mandelbox_membership_test_core_checker
// Watches the point, result and register channels, computes the expected
// membership answer for each accepted point and compares it with the results.
// ----------------------------------------------------------------------------
module mandelbox_membership_test_core_checker
    import mbox_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mbox_point_if       point,
    mbox_result_if      result,
    mbox_cfg_if         cfg,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FB      = FRACTION_BITS_DEF;
    localparam longint ONE  = 64'sd1 <<< FB;
    localparam longint QUAR = 64'sd1 <<< (FB - 2);
    localparam longint SMAX = 64'h7fff_ffff_ffff_ffff;
    localparam longint SMIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic inside_res;
        logic saturated;
    } verdict_t;

    logic [THR_W-1:0] thr_q;
    logic [CNT_W-1:0] count_q;
    verdict_t         verdict_q[$];

    function automatic longint add_clamp(input longint a, input longint b, inout bit ovf);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(SMAX))
        begin
            ovf = 1;
            return SMAX;
        end
        if (s < 65'(SMIN))
        begin
            ovf = 1;
            return SMIN;
        end
        return longint'(s);
    endfunction

    function automatic longint unsigned absval(input longint a);
        return a < 0 ? 64'(0) - 64'(a) : 64'(a);
    endfunction

    function automatic verdict_t membership(input logic signed [31:0] px,
                                            input logic signed [31:0] py,
                                            input logic signed [31:0] pz);
        longint v[3];
        longint orig[3];
        longint dr;
        bit ovf;
        bit near;
        int iters;
        longint unsigned r2;
        longint unsigned u;
        longint unsigned q;
        longint unsigned rem;
        logic [127:0] rr;
        logic [127:0] prod;
        logic [127:0] mm;
        logic [63:0] bound;
        verdict_t res;
        ovf = 0;
        dr = ONE;
        iters = (count_q > MAX_ITERATIONS_DEF) ? MAX_ITERATIONS_DEF : count_q;
        v[0] = longint'(px) * 7;
        v[1] = longint'(py) * 7;
        v[2] = longint'(pz) * 7;
        orig = v;
        for (int n = 0; n < iters; n++)
        begin
            near = 1;
            for (int i = 0; i < 3; i++)
            begin
                if (v[i] > ONE)
                    v[i] = add_clamp(2 * ONE, -v[i], ovf);
                else if (v[i] < -ONE)
                    v[i] = add_clamp(-2 * ONE, -v[i], ovf);
                if (absval(v[i]) >= ONE)
                    near = 0;
            end
            if (near)
            begin
                r2 = 0;
                for (int i = 0; i < 3; i++)
                begin
                    u = absval(v[i]);
                    r2 += (u * u) >> FB;
                end
                if (r2 < QUAR)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        v[i] = add_clamp(v[i], v[i], ovf);
                        v[i] = add_clamp(v[i], v[i], ovf);
                    end
                    dr = add_clamp(dr, dr, ovf);
                    dr = add_clamp(dr, dr, ovf);
                end
                else if (r2 < ONE)
                begin
                    q = 64'(dr) / r2;
                    rem = 64'(dr) % r2;
                    for (int i = 0; i < 3; i++)
                    begin
                        u = (absval(v[i]) << FB) / r2;
                        v[i] = v[i] < 0 ? -longint'(u) : longint'(u);
                    end
                    if (q > (64'(SMAX) >> FB))
                    begin
                        ovf = 1;
                        dr = SMAX;
                    end
                    else
                        dr = longint'((q << FB) + (rem << FB) / r2);
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                v[i] = add_clamp(v[i], v[i], ovf);
                v[i] = add_clamp(v[i], orig[i], ovf);
            end
            dr = add_clamp(dr, dr, ovf);
        end
        rr = 128'(absval(v[0])) * 128'(absval(v[0]))
           + 128'(absval(v[1])) * 128'(absval(v[1]))
           + 128'(absval(v[2])) * 128'(absval(v[2]));
        prod = 128'(64'(thr_q) * 64'd7) * 128'(64'(dr));
        if ((prod >> (64 + FB)) != 0)
        begin
            ovf = 1;
            bound = 64'(SMAX);
        end
        else
        begin
            bound = prod[64+FB-1:FB];
            if (bound > 64'(SMAX))
            begin
                ovf = 1;
                bound = 64'(SMAX);
            end
        end
        mm = 128'(bound) * 128'(bound);
        res.inside_res = rr < mm;
        res.saturated = ovf;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    assign pending = verdict_q.size();

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t exp_v;
        if (!rst_n)
        begin
            thr_q <= THRESHOLD_RESET;
            count_q <= COUNT_RESET;
            verdict_q.delete();
        end
        else
        begin
            if (point.valid && point.ready)
                verdict_q.push_back(membership(point.point_x, point.point_y, point.point_z));
            if (result.valid && result.ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result with no point outstanding");
                else
                begin
                    exp_v = verdict_q.pop_front();
                    if (result.inside_res !== exp_v.inside_res)
                        report_mismatch($sformatf("inside_res %b, expected %b",
                                                  result.inside_res, exp_v.inside_res));
                    if (result.saturated !== exp_v.saturated)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  result.saturated, exp_v.saturated));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_DISTANCE_THRESHOLD)
                    thr_q <= cfg.data[THR_W-1:0];
                else if (cfg.index == REG_ITERATION_COUNT)
                    count_q <= cfg.data[CNT_W-1:0];
            end
        end
    end

endmodule

// ===== verif/mandelbox_membership_test_core_tb.sv =====
// ----------------------------------------------------------------------------
// mandelbox_membership_test_core_tb
// Drives directed and random points through the core under several register
// settings, with random gaps on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module mandelbox_membership_test_core_tb;
    import mbox_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 38 * MAX_ITERATIONS_DEF + 9;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    bit   calm = 0;
    bit   hold_long = 0;

    mbox_point_if  point();
    mbox_result_if result();
    mbox_cfg_if    cfg();

    mandelbox_membership_test_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .result (result),
        .cfg    (cfg)
    );

    mandelbox_membership_test_core_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point),
        .result     (result),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        point.valid = 0;
        point.point_x = 0;
        point.point_y = 0;
        point.point_z = 0;
        result.ready = 0;
        cfg.valid = 0;
        cfg.index = REG_DISTANCE_THRESHOLD;
        cfg.data = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("** mandelbox_membership_test_core: FAILED **");
            $finish;
        end
    end

    // result side: random stall bursts, none while calm or held
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
                result.ready <= 0;
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 15);
                result.ready <= 0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                result.ready <= 1;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
    endtask

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            point.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        point.valid <= 1;
        point.point_x <= x;
        point.point_y <= y;
        point.point_z <= z;
        do @(posedge clk); while (!point.ready);
    endtask

    // mostly near the box where the folds matter; some anywhere
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
            default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
        endcase
    endfunction

    task automatic settle_and_write(input cfg_idx_t idx, input logic [31:0] val);
        point.valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        write_reg(idx, val);
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    initial
    begin
        logic [31:0] edges[6];
        edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                  32'h0100_0000, 32'h0008_0000};
        @(posedge rst_n);
        @(posedge clk);
        // directed: extremes, tiny and mid radii, default registers
        for (int i = 0; i < 6; i++)
            send_point(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
        send_point(32'h0002_0000, 32'h0001_0000, 32'hfffe_0000);
        send_point(32'h0008_0000, 32'hfff8_0000, 32'h0004_0000);
        send_point(32'h0024_9249, 32'h0, 32'h0);
        send_point(32'hffdb_6db7, 32'h0012_0000, 32'h0);
        send_point(32'h0, 32'h0, 32'h0);
        random_phase(150);

        // long hold-off on the result side; keep offering points until it ends
        hold_long = 1;
        fork
            while (hold_long)
                send_point(rand_coord(), rand_coord(), rand_coord());
            begin
                repeat (LATENCY + 200) @(posedge clk);
                hold_long = 0;
            end
        join

        settle_and_write(REG_ITERATION_COUNT, 32'd0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
        random_phase(60);
        settle_and_write(REG_ITERATION_COUNT, 32'd31);
        settle_and_write(REG_DISTANCE_THRESHOLD, 32'hffff_ffff);
        random_phase(120);
        settle_and_write(REG_DISTANCE_THRESHOLD, 32'd0);
        random_phase(60);
        settle_and_write(REG_ITERATION_COUNT, 32'd16);
        settle_and_write(REG_DISTANCE_THRESHOLD, 32'h0100_0000);
        random_phase(120);
        settle_and_write(REG_ITERATION_COUNT, 32'd3);
        settle_and_write(cfg_idx_t'(4'd9), 32'hdead_beef);
        settle_and_write(REG_DISTANCE_THRESHOLD, $urandom);
        random_phase(150);
        settle_and_write(REG_ITERATION_COUNT, 32'd1);
        random_phase(80);
        calm = 1;
        settle_and_write(REG_ITERATION_COUNT, 32'd10);
        random_phase(100);
        point.valid <= 0;

        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("** mandelbox_membership_test_core: PASSED **");
        else
            $display("** mandelbox_membership_test_core: FAILED **");
        $finish;
    end

endmodule
